>>> design/tlpc_pkg.sv
// Shared types, constants and light-update functions for the traffic light
// preemption controller. Used by every module under design/.
`timescale 1ns / 1ps

package tlpc_pkg;

  // Light codes as carried on the result stream
  typedef enum logic [1:0] {
    LAMP_RED    = 2'd0,
    LAMP_YELLOW = 2'd1,
    LAMP_GREEN  = 2'd2
  } light_t;

  localparam int NUM_DIRS  = 4;
  localparam int DIR_W     = 3;
  localparam int TICK_W    = 8;
  // Phase timer spans -255 .. 257 while a tick is worked out
  localparam int TIMER_W   = 10;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_TICK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_TICK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY_HOLD = 2'd2;

  localparam logic [TICK_W-1:0] YELLOW_TICK_RST    = 8'd60;
  localparam logic [TICK_W-1:0] CHANGE_TICK_RST    = 8'd80;
  localparam logic [TICK_W-1:0] EMERGENCY_HOLD_RST = 8'd100;

  typedef light_t lights_t [NUM_DIRS];

  typedef struct packed {
    logic [TICK_W-1:0] yellow_tick;
    logic [TICK_W-1:0] change_tick;
    logic [TICK_W-1:0] emergency_hold;
  } cfg_t;

  typedef struct packed {
    logic             started;
    logic             local_emergency;
    logic [DIR_W-1:0] local_dir;
    logic             remote_emergency;
    logic [DIR_W-1:0] remote_dir;
  } item_t;

  typedef struct packed {
    logic [1:0]       north_light;
    logic [1:0]       south_light;
    logic [1:0]       east_light;
    logic [1:0]       west_light;
    logic             in_emergency;
    logic             send_emergency;
    logic [DIR_W-1:0] send_dir;
  } result_t;

  // All red, then the given direction green when it names one
  function automatic lights_t favor_dir(input logic [DIR_W-1:0] dir);
    lights_t l;
    for (int i = 0; i < NUM_DIRS; i++) begin
      l[i] = (dir == DIR_W'(i)) ? LAMP_GREEN : LAMP_RED;
    end
    return l;
  endfunction

  // Turn the first green light yellow
  function automatic lights_t green_to_yellow(input lights_t cur);
    lights_t l;
    logic    done;
    l = cur;
    done = 1'b0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (!done && cur[i] == LAMP_GREEN) begin
        l[i] = LAMP_YELLOW;
        done = 1'b1;
      end
    end
    return l;
  endfunction

  // Give green to the direction after the first lit one; north when none
  function automatic lights_t advance_dir(input lights_t cur);
    lights_t l;
    logic    done;
    l = favor_dir('0);
    done = 1'b0;
    for (int i = 0; i < NUM_DIRS - 1; i++) begin
      if (!done && (cur[i] == LAMP_YELLOW || cur[i] == LAMP_GREEN)) begin
        l = favor_dir(DIR_W'(i + 1));
        done = 1'b1;
      end
    end
    return l;
  endfunction

endpackage

>>> design/tlpc_in_reg.sv
// Input register stage of the stream: holds one accepted tick word.
// Depends on tlpc_pkg for the item layout.
`timescale 1ns / 1ps

module tlpc_in_reg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tlpc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                               take,
  output logic                               item_valid,
  output tlpc_pkg::item_t                    item
);

  logic            valid;
  tlpc_pkg::item_t data;

  // Room when empty or when the held word moves on this cycle
  assign s_tready   = !valid || take;
  assign item_valid = valid;
  assign item       = data;

  // Hold the accepted word until the core consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Unpack lowest field first
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data.started          <= s_tdata[0];
      data.local_emergency  <= s_tdata[1];
      data.local_dir        <= s_tdata[4:2];
      data.remote_emergency <= s_tdata[5];
      data.remote_dir       <= s_tdata[8:6];
    end
  end

  logic unused_pad;
  assign unused_pad = ^s_tdata[tlpc_pkg::IN_DATA_W-1:9];

endmodule

>>> design/tlpc_core.sv
// Controller state (lights, phase timer, emergency flag) and the per-tick
// update logic. Depends on tlpc_pkg for types and light functions.
`timescale 1ns / 1ps

module tlpc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tlpc_pkg::item_t   item,
  input  tlpc_pkg::cfg_t    cfg,
  output tlpc_pkg::result_t result
);

  tlpc_pkg::lights_t                    lights;
  tlpc_pkg::lights_t                    lights_next;
  logic signed [tlpc_pkg::TIMER_W-1:0]  timer;
  logic signed [tlpc_pkg::TIMER_W-1:0]  timer_next;
  logic                                 flag;
  logic                                 flag_next;
  logic signed [tlpc_pkg::TIMER_W-1:0]  hold_neg;
  logic signed [tlpc_pkg::TIMER_W-1:0]  yellow_s;
  logic signed [tlpc_pkg::TIMER_W-1:0]  change_s;
  logic                                 send;
  logic [tlpc_pkg::DIR_W-1:0]           send_dir;

  assign hold_neg = -$signed({2'b00, cfg.emergency_hold});
  assign yellow_s = $signed({2'b00, cfg.yellow_tick});
  assign change_s = $signed({2'b00, cfg.change_tick});

  // Work out one tick
  always_comb begin
    lights_next = lights;
    timer_next  = timer;
    flag_next   = flag;
    send        = 1'b0;
    send_dir    = '0;
    if (item.started) begin
      if (item.local_emergency) begin
        flag_next   = 1'b1;
        lights_next = tlpc_pkg::favor_dir(item.local_dir);
        timer_next  = hold_neg;
        send        = 1'b1;
        send_dir    = item.local_dir;
      end
      if (item.remote_emergency) begin
        flag_next   = 1'b1;
        lights_next = tlpc_pkg::favor_dir(item.remote_dir);
        timer_next  = hold_neg;
      end
      timer_next = timer_next + 10'sd1;
      if (!flag_next) begin
        if (timer_next == yellow_s) begin
          lights_next = tlpc_pkg::green_to_yellow(lights_next);
        end else if (timer_next > change_s) begin
          lights_next = tlpc_pkg::advance_dir(lights_next);
          timer_next  = '0;
        end
      end else if (timer_next > 10'sd0) begin
        // Hold over: rotate on the next tick with no yellow
        flag_next  = 1'b0;
        timer_next = change_s + 10'sd1;
      end
    end
  end

  // Result as the lights stand after the tick
  always_comb begin
    result.north_light    = lights_next[0];
    result.south_light    = lights_next[1];
    result.east_light     = lights_next[2];
    result.west_light     = lights_next[3];
    result.in_emergency   = flag_next;
    result.send_emergency = send;
    result.send_dir       = send_dir;
  end

  // Advance state once per consumed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tlpc_pkg::NUM_DIRS; i++) begin
        lights[i] <= tlpc_pkg::LAMP_RED;
      end
      timer <= '0;
      flag  <= 1'b0;
    end else if (step) begin
      lights <= lights_next;
      timer  <= timer_next;
      flag   <= flag_next;
    end
  end

  // At most one light is ever lit
  a_one_lit: assert property (@(posedge clk) disable iff (rst)
    $countones({lights[0] != tlpc_pkg::LAMP_RED, lights[1] != tlpc_pkg::LAMP_RED,
                lights[2] != tlpc_pkg::LAMP_RED, lights[3] != tlpc_pkg::LAMP_RED}) <= 1)
    else $error("more than one light lit");

  // No yellow during an emergency hold
  a_no_yellow_hold: assert property (@(posedge clk) disable iff (rst)
    flag |-> (lights[0] != tlpc_pkg::LAMP_YELLOW && lights[1] != tlpc_pkg::LAMP_YELLOW &&
              lights[2] != tlpc_pkg::LAMP_YELLOW && lights[3] != tlpc_pkg::LAMP_YELLOW))
    else $error("yellow light during emergency hold");

  // Outside a hold the timer never runs negative
  a_timer_sign: assert property (@(posedge clk) disable iff (rst)
    !flag |-> timer >= 10'sd0)
    else $error("negative phase timer outside hold");

  // Timer and emergency flag hold across cycles with no tick consumed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(timer) && $stable(flag))
    else $error("state changed without a tick");

endmodule

>>> design/tlpc_out_reg.sv
// Result register of the stream: holds one finished result word.
// Depends on tlpc_pkg for the result layout.
`timescale 1ns / 1ps

module tlpc_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  tlpc_pkg::result_t               result,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tlpc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            room
);

  logic              valid;
  tlpc_pkg::result_t data;

  // Room when empty or when the held word leaves this cycle
  assign room     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = {3'b000, data.send_dir, data.send_emergency, data.in_emergency,
                     data.west_light, data.east_light, data.south_light, data.north_light};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  // Capture the result of the consumed tick
  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

>>> design/traffic_light_preemption_controller_top.sv
// Top level of the four-way traffic light controller with emergency
// preemption. Instantiates tlpc_in_reg, tlpc_core, tlpc_out_reg; uses tlpc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Each word on the s_ stream is one controller tick; each tick yields
//   exactly one result word on the m_ stream, in order.
//   Ticks with started low leave the state alone and report current lights.
//   Configuration (yellow_tick, change_tick, emergency_hold) is written via
//   cfg_we / cfg_index / cfg_data while the stream is idle; index 3 is ignored.
// Pipeline: an accepted word passes through two register stages, the input
//   register and then the result register.
// Throughput: one word per cycle while m_tready stays high; the state update
//   is a single short step between the input register and the result register.
// Reset (rst, synchronous): all lights red, timer zero, no emergency,
//   registers back to 60 / 80 / 100, both stages empty.
// Stall: when m_tready is low the result register holds its word, the
//   input register still takes one more word, and s_tready then drops
//   until the result moves on.

module traffic_light_preemption_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // started, local_emergency, local_dir[2:0], remote_emergency,
  // remote_dir[2:0], zero pad
  input  logic [tlpc_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // north_light[1:0], south_light[1:0], east_light[1:0], west_light[1:0],
  // in_emergency, send_emergency, send_dir[2:0], zero pad
  output logic [tlpc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlpc_pkg::TICK_W-1:0]       cfg_data
);

  tlpc_pkg::cfg_t    cfg;
  tlpc_pkg::item_t   item;
  tlpc_pkg::result_t result;
  logic              item_valid;
  logic              room;
  logic              step;

  // Move a tick through when one is held and the result stage has room
  assign step = item_valid && room;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.yellow_tick    <= tlpc_pkg::YELLOW_TICK_RST;
      cfg.change_tick    <= tlpc_pkg::CHANGE_TICK_RST;
      cfg.emergency_hold <= tlpc_pkg::EMERGENCY_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tlpc_pkg::REG_YELLOW_TICK:    cfg.yellow_tick    <= cfg_data;
        tlpc_pkg::REG_CHANGE_TICK:    cfg.change_tick    <= cfg_data;
        tlpc_pkg::REG_EMERGENCY_HOLD: cfg.emergency_hold <= cfg_data;
        default: ;
      endcase
    end
  end

  tlpc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  tlpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  tlpc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .room     (room)
  );

endmodule
